// ===== rtl/text_console_writer_top_assert.svh =====
// ----------------------------------------------------------------------------
// text console writer assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define TCW_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked at every clock edge, reset included
`define TCW_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TCW_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define TCW_ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int IDX_W   = 11;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int WORD_W  = 16;
    localparam int COLOR_W = 4;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BACKGROUND = 2'd0,
        REG_FOREGROUND = 2'd1
    } cfg_reg_t;

    // controller states
    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_COPY  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_FILL  = 5'b10000
    } state_t;

    // one result word
    typedef struct packed {
        logic [WORD_W-1:0] cell_word;
        logic [IDX_W-1:0]  cell_index;
        logic              cell_written;
        logic              scrolled;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
    } res_t;

endpackage

// ===== rtl/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top
// text console writer: cell store of ROWS x COLUMNS words, cursor, put / move / clear
// ----------------------------------------------------------------------------
// results: put and move words show on m_ side in the cycle after acceptance;
//   a put that scrolls and a clear report theirs once the walk over the ram has finished
// throughput: one put or move per cycle while the output register is free; scroll and clear
//   walk the cell ram one cell per cycle through its single write port and hold s_tready low meanwhile
// reset: aresetn synchronous active low; afterwards a clearing pass over every cell fills
//   the ram with blanks before s_tready rises; cfg writes are taken throughout
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // command stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // char_code, target_row, target_column, pad
    input  logic [CMD_W-1:0]     s_tuser,   // cmd
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // cursor_row_out, cursor_column_out,
                                            // cell_index, cell_word, pad
    output logic [1:0]           m_tuser,   // scrolled, cell_written
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    // color registers
    logic [COLOR_W-1:0] bg_reg, fg_reg;
    logic [ATTR_W-1:0]  attr;

    // output register
    logic               m_valid_reg;
    res_t               m_res_reg;
    logic               out_free;

    // controller to ram
    logic               res_valid;
    res_t               res;
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    // config port never stalls
    assign cfg_ready = 1'b1;
    assign attr      = {bg_reg, fg_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_reg <= '0;
            fg_reg <= '1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BACKGROUND: bg_reg <= cfg_data;
                REG_FOREGROUND: fg_reg <= cfg_data;
                default: ;  // unknown register index ignored
            endcase
        end
    end

    // output stage is free when empty or draining this cycle
    assign out_free = !m_valid_reg || m_tready;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_char   (s_tdata[7:0]),
        .in_row    (s_tdata[12:8]),
        .in_col    (s_tdata[19:13]),
        .attr      (attr),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // result word register: loads on a new result, clears once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.cell_word, m_res_reg.cell_index,
                       m_res_reg.cursor_column, m_res_reg.cursor_row};
    assign m_tuser  = {m_res_reg.cell_written, m_res_reg.scrolled};

endmodule

// ===== rtl/tcw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_cell_ram
// single-port-write, single-port-read text cell memory, registered read
// ----------------------------------------------------------------------------
module tcw_cell_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem_array [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// cursor tracking, command decode and the scroll / clear walker over the ram
// ----------------------------------------------------------------------------
`include "text_console_writer_top_assert.svh"

module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int ADDR_W  = 11
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  in_cmd,
    input  logic [CHAR_W-1:0] in_char,
    input  logic [ROW_W-1:0]  in_row,
    input  logic [COL_W-1:0]  in_col,
    input  logic [ATTR_W-1:0] attr,
    input  logic              out_free,
    output logic              res_valid,
    output res_t              res,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [WORD_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [WORD_W-1:0] ram_rdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM    = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [ADDR_W-1:0]   cur_addr_reg, cur_addr_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [WORD_W-1:0]   blank_reg, blank_next;
    res_t                res_hold_reg, res_hold_next;

    res_t                res_now;
    logic                accept;
    logic [ROW_W-1:0]    row_cl;
    logic [COL_W-1:0]    col_cl;
    logic [ADDR_W+IDX_W-1:0] idx_ext;

    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign row_cl   = (in_row > ROW_LAST) ? ROW_LAST : in_row;
    assign col_cl   = (in_col > COL_LAST) ? COL_LAST : in_col;
    assign idx_ext  = {{IDX_W{1'b0}}, cur_addr_reg};

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cur_addr_next  = cur_addr_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        blank_next     = blank_reg;
        res_hold_next  = res_hold_reg;
        res_valid      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = blank_reg;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg + COLS_A;
        res_now        = '0;

        // copy write happens in the cycle after its read
        if (pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = ram_rdata;
        end

        case (state_reg)
            ST_INIT: begin
                ram_we = 1'b1;
                if (idx_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_PUT: begin
                            ram_we                = 1'b1;
                            ram_waddr             = cur_addr_reg;
                            ram_wdata             = {attr, in_char};
                            res_now.cell_written  = 1'b1;
                            res_now.cell_index    = idx_ext[IDX_W-1:0];
                            res_now.cell_word     = {attr, in_char};
                            res_valid             = 1'b1;
                            if (cur_col_reg == COL_LAST) begin
                                cur_col_next = '0;
                                if (cur_row_reg == ROW_LAST) begin
                                    // bottom row full: scroll up
                                    cur_addr_next    = BOTTOM;
                                    res_now.scrolled = 1'b1;
                                    res_valid        = 1'b0;
                                    idx_next         = '0;
                                    blank_next       = {attr, BLANK_CHAR};
                                    state_next       = ST_COPY;
                                end else begin
                                    cur_row_next  = cur_row_reg + 1'b1;
                                    cur_addr_next = cur_addr_reg + 1'b1;
                                end
                            end else begin
                                cur_col_next  = cur_col_reg + 1'b1;
                                cur_addr_next = cur_addr_reg + 1'b1;
                            end
                        end
                        CMD_MOVE: begin
                            cur_row_next  = row_cl;
                            cur_col_next  = col_cl;
                            cur_addr_next = ADDR_W'(row_cl) * COLS_A + ADDR_W'(col_cl);
                            res_valid     = 1'b1;
                        end
                        CMD_CLEAR: begin
                            cur_row_next  = '0;
                            cur_col_next  = '0;
                            cur_addr_next = '0;
                            idx_next      = '0;
                            blank_next    = {attr, BLANK_CHAR};
                            state_next    = ST_FILL;
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                    res_now.cursor_row    = cur_row_next;
                    res_now.cursor_column = cur_col_next;
                    res_hold_next         = res_now;
                end
            end
            ST_COPY: begin
                ram_re         = 1'b1;
                pend_next      = 1'b1;
                pend_addr_next = idx_reg;
                if (idx_reg == COPY_LAST) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                idx_next   = BOTTOM;
                state_next = ST_FILL;
            end
            ST_FILL: begin
                ram_we = 1'b1;
                if (idx_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                    res_valid  = 1'b1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = (state_reg == ST_IDLE) ? res_now : res_hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            idx_reg      <= '0;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            cur_addr_reg <= '0;
            pend_reg     <= 1'b0;
            blank_reg    <= {RESET_ATTR, BLANK_CHAR};
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            cur_addr_reg <= cur_addr_next;
            pend_reg     <= pend_next;
            blank_reg    <= blank_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        res_hold_reg  <= res_hold_next;
    end

    `TCW_ASSERT_RST(a_cursor_in_range, aclk, aresetn, (cur_row_reg <= ROW_LAST) && (cur_col_reg <= COL_LAST), "cursor outside the screen")
    `TCW_ASSERT_RST(a_addr_tracks_cursor, aclk, aresetn, (state_reg == ST_IDLE) |-> (cur_addr_reg == ADDR_W'(cur_row_reg) * COLS_A + ADDR_W'(cur_col_reg)), "linear cursor address out of step")
    `TCW_ASSERT_RST(a_idle_write_is_put, aclk, aresetn, (ram_we && (state_reg == ST_IDLE)) |-> (accept && (in_cmd == CMD_PUT)), "cell write while idle without a put")
    `TCW_ASSERT_RST(a_result_has_room, aclk, aresetn, res_valid |-> out_free, "result produced with output register full")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the text console writer: drives put, move, clear and
// unused commands under several color settings, tracks the cursor and the
// attribute in a scoreboard and compares every result word field by field
// ----------------------------------------------------------------------------
module tb_top;
    import tcw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int IDLE_LIMIT   = 20000;  // cycles without any handshake
    localparam int DRAIN_CYCLES = 2100;   // longer than a full scroll or clear pass
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off

    // code that the block must ignore, and register slots that do not exist
    localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // ------------------------------------------------------------------------
    // scoreboard: cursor and color copy, queue of expected result words
    // cell contents never reach the ports, so only cursor and attribute matter
    // ------------------------------------------------------------------------
    class console_scoreboard;
        logic [COLOR_W-1:0] bg_color;
        logic [COLOR_W-1:0] fg_color;
        logic [ROW_W-1:0]   cur_row;
        logic [COL_W-1:0]   cur_col;
        res_t               expected_words[$];
        int unsigned        errors, checked, puts, scrolls, clears;

        function new();
            bg_color = '0;
            fg_color = 4'hF;
            cur_row  = '0;
            cur_col  = '0;
            errors   = 0;
            checked  = 0;
            puts     = 0;
            scrolls  = 0;
            clears   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
            case (idx)
                REG_BACKGROUND: bg_color = val;
                REG_FOREGROUND: fg_color = val;
                default: ;
            endcase
        endfunction

        function void note_command(logic [CMD_W-1:0] op, logic [CHAR_W-1:0] ch,
                                   logic [ROW_W-1:0] trow, logic [COL_W-1:0] tcol);
            res_t w;
            w = '0;
            case (op)
                CMD_PUT: begin
                    puts++;
                    w.cell_written = 1'b1;
                    w.cell_index   = IDX_W'(int'(cur_row) * COLUMNS + int'(cur_col));
                    w.cell_word    = {bg_color, fg_color, ch};
                    if (int'(cur_col) == COLUMNS - 1) begin
                        cur_col = '0;
                        if (int'(cur_row) == ROWS - 1) begin
                            w.scrolled = 1'b1;  // row stays at the bottom
                            scrolls++;
                        end else begin
                            cur_row = cur_row + 1'b1;
                        end
                    end else begin
                        cur_col = cur_col + 1'b1;
                    end
                end
                CMD_MOVE: begin
                    cur_row = (int'(trow) > ROWS - 1) ? ROW_W'(ROWS - 1) : trow;
                    cur_col = (int'(tcol) > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : tcol;
                end
                CMD_CLEAR: begin
                    cur_row = '0;
                    cur_col = '0;
                    clears++;
                end
                default: ;
            endcase
            w.cursor_row    = cur_row;
            w.cursor_column = cur_col;
            expected_words.push_back(w);
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(res_t got);
            res_t want;
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: row %0d column %0d",
                       got.cursor_row, got.cursor_column);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            checked++;
            field_check("cursor_row_out",    want.cursor_row,    got.cursor_row);
            field_check("cursor_column_out", want.cursor_column, got.cursor_column);
            field_check("scrolled",          want.scrolled,      got.scrolled);
            field_check("cell_written",      want.cell_written,  got.cell_written);
            field_check("cell_index",        want.cell_index,    got.cell_index);
            field_check("cell_word",         want.cell_word,     got.cell_word);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;   // char_code, target_row, target_column, pad
    logic [CMD_W-1:0]     s_tuser;   // cmd
    logic                 m_tvalid;
    logic                 m_tready;
    logic [39:0]          m_tdata;   // cursor_row_out, cursor_column_out,
                                     // cell_index, cell_word, pad
    logic [1:0]           m_tuser;   // scrolled, cell_written
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_data;

    console_scoreboard sb;
    bit          hold_req;      // asks the receiver for one long hold-off
    int unsigned burst_left;    // words left in the current sender burst
    int unsigned n_sent;
    int unsigned n_cfg;
    int unsigned idle_cycles;

    text_console_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // monitor: commands are noted before results, both at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        res_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_command(s_tuser, s_tdata[7:0], s_tdata[12:8], s_tdata[19:13]);
            if (m_tvalid && m_tready) begin
                got               = '0;
                got.cursor_row    = m_tdata[4:0];
                got.cursor_column = m_tdata[11:5];
                got.cell_index    = m_tdata[22:12];
                got.cell_word     = m_tdata[38:23];
                got.scrolled      = m_tuser[0];
                got.cell_written  = m_tuser[1];
                sb.check_word(got);
            end
        end
    end

    // watchdog: any handshake on any channel counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern switching between randomly chosen modes,
    // plus a long hold-off on request so the block backs up into s_tready
    // ------------------------------------------------------------------------
    initial begin
        int unsigned mode_left;
        int unsigned stall_mode;
        int unsigned tick;
        mode_left  = 0;
        stall_mode = 0;
        tick       = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 128);
                end
                mode_left--;
                case (stall_mode)
                    0:       m_tready = 1'b1;                           // no stalls
                    1:       m_tready = ($urandom_range(0, 1) == 0);
                    2:       m_tready = ($urandom_range(0, 4) != 0);
                    default: m_tready = ((tick % 7) < 2);               // mostly stalled
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks, entered and left at a falling edge
    // ------------------------------------------------------------------------

    // one command word; the sender works in bursts with random gaps between them
    task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [ROW_W-1:0] trow, input logic [COL_W-1:0] tcol);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'b0, tcol, trow, ch};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic put_random();
        send_cmd(CMD_PUT, CHAR_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 31)),
                 COL_W'($urandom_range(0, 127)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        n_cfg++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // stop offering, wait for every result, then let a scroll or clear finish
    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // random traffic, mostly runs of puts that wrap lines and scroll the screen
    task automatic random_items(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned run;
        stop_at = n_sent + count;
        while (n_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                put_random();
            end else if (pick < 70) begin
                send_cmd(CMD_MOVE, CHAR_W'($urandom_range(0, 255)),
                         ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
            end else if (pick < 80) begin
                // park near the bottom right corner, then write past it
                send_cmd(CMD_MOVE, CHAR_W'($urandom_range(0, 255)),
                         ROW_W'($urandom_range(23, 31)), COL_W'($urandom_range(60, 127)));
                run = $urandom_range(1, 40);
                repeat (run) put_random();
            end else if (pick < 85) begin
                send_cmd(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                         ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
            end else if (pick < 90) begin
                send_cmd(CMD_SPARE, CHAR_W'($urandom_range(0, 255)),
                         ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
            end else begin
                // line end on a random row
                send_cmd(CMD_MOVE, CHAR_W'($urandom_range(0, 255)),
                         ROW_W'($urandom_range(0, 24)), COL_W'($urandom_range(70, 79)));
                run = $urandom_range(5, 20);
                repeat (run) put_random();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [COLOR_W-1:0] bg_set [6];
        logic [COLOR_W-1:0] fg_set [6];

        sb          = new();
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_req    = 1'b0;
        burst_left  = 0;
        n_sent      = 0;
        n_cfg       = 0;
        idle_cycles = 0;

        // single reset at the start; the clearing pass after it is covered
        // by s_tready staying low
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part at the reset colors
        send_cmd(CMD_PUT,   8'h00, 5'd0,  7'd0);
        send_cmd(CMD_PUT,   8'hFF, 5'd31, 7'd127);  // fields a put ignores
        send_cmd(CMD_MOVE,  8'h00, 5'd0,  7'd0);
        send_cmd(CMD_MOVE,  8'hFF, 5'd31, 7'd127);  // both clamp to the corner
        send_cmd(CMD_PUT,   8'h41, 5'd0,  7'd0);    // last cell: wrap and scroll
        send_cmd(CMD_MOVE,  8'h00, 5'd24, 7'd127);
        send_cmd(CMD_MOVE,  8'h00, 5'd31, 7'd0);
        send_cmd(CMD_MOVE,  8'h00, 5'd24, 7'd79);
        send_cmd(CMD_PUT,   8'h7F, 5'd0,  7'd0);
        send_cmd(CMD_MOVE,  8'h00, 5'd5,  7'd79);
        send_cmd(CMD_PUT,   8'h80, 5'd0,  7'd0);    // line end without scroll
        send_cmd(CMD_SPARE, 8'hFF, 5'd31, 7'd127);  // unused code changes nothing
        send_cmd(CMD_SPARE, 8'h00, 5'd0,  7'd0);
        send_cmd(CMD_CLEAR, 8'hAA, 5'd17, 7'd42);
        send_cmd(CMD_PUT,   8'h55, 5'd10, 7'd10);
        send_cmd(CMD_MOVE,  8'h00, 5'd24, 7'd80);   // one past the last column
        send_cmd(CMD_MOVE,  8'h00, 5'd25, 7'd0);    // one past the last row
        send_cmd(CMD_MOVE,  8'h00, 5'd24, 7'd78);
        send_cmd(CMD_PUT,   8'h31, 5'd0,  7'd0);
        send_cmd(CMD_PUT,   8'h32, 5'd0,  7'd0);    // scroll
        send_cmd(CMD_PUT,   8'h33, 5'd0,  7'd0);
        settle();

        // color settings per phase, extremes first
        bg_set = '{4'h0, 4'hF, 4'hF, 4'h0, 4'h0, 4'h0};
        fg_set = '{4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'h0};
        bg_set[4] = COLOR_W'($urandom_range(0, 15));
        fg_set[4] = COLOR_W'($urandom_range(0, 15));
        bg_set[5] = COLOR_W'($urandom_range(0, 15));
        fg_set[5] = COLOR_W'($urandom_range(0, 15));

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_BACKGROUND, bg_set[p]);
            write_reg(REG_FOREGROUND, fg_set[p]);
            if (p == 2) begin
                // writes to missing registers must not disturb the colors
                write_reg(REG_SPARE_A, COLOR_W'($urandom_range(0, 15)));
                write_reg(REG_SPARE_B, COLOR_W'($urandom_range(0, 15)));
            end
            if (p == 0 || p == 3) begin
                // long receiver hold while the sender keeps pushing puts
                hold_req = 1'b1;
                repeat (40) put_random();
            end
            random_items(195);
            settle();
        end

        if (sb.pending() != 0) begin
            $error("%0d expected result words never arrived", sb.pending());
            sb.errors++;
        end

        $display("covered %0d commands: %0d puts, %0d scrolls, %0d clears; %0d words checked",
                 n_sent, sb.puts, sb.scrolls, sb.clears, sb.checked);
        $display("%0d register writes across 6 color settings incl. all-zero and all-one",
                 n_cfg);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_cell_ram.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_top.sv
dv/tb_top.sv
